// ----- src/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants for the first-fit heap allocator
// Beat payload structs, command codes and header field constants.
// ----------------------------------------------------------------------------
package ffha_pkg;

  typedef enum logic [2:0] {
    OP_INIT       = 3'd0,
    OP_ALLOC      = 3'd1,
    OP_FREE       = 3'd2,
    OP_CHECK_BLK  = 3'd3,
    OP_CHECK_HEAP = 3'd4
  } ffha_op_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] request_size;
    logic [15:0] payload_offset;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] result_offset;
  } out_item_t;

  localparam logic [15:0] VALID_MARK    = 16'hA3A3;
  localparam logic [31:0] HDR_BYTES     = 32'd16;
  localparam logic [31:0] MAX_SLACK     = 32'd31;
  localparam logic [31:0] MIN_HEAP      = 32'd32;
  localparam logic [16:0] HEAP_SIZE_RST = 17'h10000;

  // header word offsets within a block
  localparam logic [1:0] HW_FLAG = 2'd0;
  localparam logic [1:0] HW_SIZE = 2'd1;
  localparam logic [1:0] HW_PREV = 2'd2;
  localparam logic [1:0] HW_NEXT = 2'd3;

  // configuration register indexes
  localparam logic REG_HEAP_SIZE = 1'b0;

endpackage

// ----- src/ffha_hdr_ram.sv -----
// ----------------------------------------------------------------------------
// ffha_hdr_ram: header store
// Single-port synchronous RAM, one write or one read per cycle, registered
// read data.
// ----------------------------------------------------------------------------
module ffha_hdr_ram #(
  parameter int AW = 14,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit heap manager with coalescing
// Sequencer that walks and edits block headers held in a word RAM.
// ----------------------------------------------------------------------------
// Every command runs as a sequence of single-word RAM accesses (one per
// cycle, registered read data), so timing is set by the one header
// RAM port. Init writes the four header words of one free block. Alloc
// reads flag, size and next link of each free block visited and flag and
// next link of each block in use, then writes the new headers if it splits.
// Check heap repeats the block check for each block in the chain. ST_FIN
// loads the output register, waiting while out_stall holds it. After reset
// the block sweeps 2^(HEAP_ADDR_BITS-2) header words to zero and holds
// in_stall high until done.
module first_fit_heap_allocator #(
  parameter int HEAP_ADDR_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ffha_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ffha_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ffha_pkg::*;

  localparam int H  = HEAP_ADDR_BITS;
  localparam int W  = HEAP_ADDR_BITS - 2;
  localparam int CW = HEAP_ADDR_BITS - 4;
  localparam logic [31:0] HEAP_BYTES = 32'(1) << HEAP_ADDR_BITS;

  typedef enum logic [5:0] {
    ST_CLEAR, ST_IDLE, ST_FIN,
    ST_IN_W0, ST_IN_W1, ST_IN_W2, ST_IN_W3,
    ST_AL_RD0, ST_AL_FLAG, ST_AL_SIZE, ST_AL_NEXT,
    ST_SP_NX, ST_SP_W1, ST_SP_H0, ST_SP_H1, ST_SP_H2, ST_SP_H3,
    ST_SP_LINK, ST_SP_RD, ST_SP_PREV,
    ST_FR_0, ST_FR_1, ST_FR_2, ST_FR_3, ST_FR_4, ST_FR_5, ST_FR_6,
    ST_FR_7, ST_FR_8, ST_FR_9, ST_FR_10, ST_FR_11, ST_FR_12,
    ST_FR_P0, ST_FR_P1, ST_FR_P2, ST_FR_P3, ST_FR_P4, ST_FR_P5, ST_FR_P6,
    ST_FR_P8, ST_FR_P9, ST_FR_P10, ST_FR_P11, ST_FR_P12, ST_FR_P13,
    ST_CK_0, ST_CK_1, ST_CK_2, ST_CK_3, ST_CK_4, ST_CK_5, ST_CK_6,
    ST_CK_7, ST_CK_8, ST_CK_9, ST_CK_10
  } state_t;

  state_t         state_r, state_nxt;
  logic [W-1:0]   clr_r, clr_nxt;
  logic [H-1:0]   b_r, b_nxt;
  logic [H-1:0]   n_r, n_nxt;
  logic [H-1:0]   pv_r, pv_nxt;
  logic [H-1:0]   sp_r, sp_nxt;
  logic [31:0]    sz_r, sz_nxt;
  logic [31:0]    w0_r, w0_nxt;
  logic [31:0]    t_r, t_nxt;
  logic [31:0]    rest_r, rest_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           heap_r, heap_nxt;
  logic           res_ok_r, res_ok_nxt;
  logic [15:0]    res_off_r, res_off_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_data_r, out_data_nxt;
  logic [16:0]    heap_size_r;

  logic           mem_we;
  logic [W-1:0]   mem_addr;
  logic [31:0]    mem_wd;
  logic [31:0]    rd;
  logic [H-1:0]   rd_n;
  logic           chk_done, chk_ok;
  logic [31:0]    hs, init_e;
  logic [H-1:0]   ptr_h, ptr_b;
  logic [31:0]    req_ext;

  function automatic logic [W-1:0] widx(input logic [H-1:0] base, input logic [1:0] k);
    return base[H-1:2] + W'(k);
  endfunction

  function automatic logic [H-1:0] norm(input logic [H-1:0] a);
    return {a[H-1:2], 2'b00};
  endfunction

  ffha_hdr_ram #(.AW(W), .DW(32)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wd),
    .rdata (rd)
  );

  assign rd_n    = norm(rd[H-1:0]);
  assign ptr_h   = H'(in_data.payload_offset);
  assign ptr_b   = norm(ptr_h - H'(HDR_BYTES));
  assign req_ext = {16'd0, in_data.request_size};

  // init size: word aligned, clamped to 32 .. heap span
  always_comb begin
    hs = {15'd0, heap_size_r[16:2], 2'b00};
    if (hs > HEAP_BYTES) begin
      init_e = HEAP_BYTES;
    end else if (hs < MIN_HEAP) begin
      init_e = MIN_HEAP;
    end else begin
      init_e = hs;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    b_nxt         = b_r;
    n_nxt         = n_r;
    pv_nxt        = pv_r;
    sp_nxt        = sp_r;
    sz_nxt        = sz_r;
    w0_nxt        = w0_r;
    t_nxt         = t_r;
    rest_nxt      = rest_r;
    cnt_nxt       = cnt_r;
    heap_nxt      = heap_r;
    res_ok_nxt    = res_ok_r;
    res_off_nxt   = res_off_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_addr      = widx(b_r, HW_FLAG);
    mem_wd        = '0;
    chk_done      = 1'b0;
    chk_ok        = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
        clr_nxt  = clr_r + W'(1);
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          res_ok_nxt  = 1'b0;
          res_off_nxt = '0;
          cnt_nxt     = '0;
          heap_nxt    = 1'b0;
          case (in_data.opcode)
            OP_INIT: state_nxt = ST_IN_W0;
            OP_ALLOC: begin
              sz_nxt    = (req_ext[1:0] != 2'b00) ? ((req_ext | 32'd3) + 32'd1) : req_ext;
              b_nxt     = '0;
              state_nxt = ST_AL_RD0;
            end
            OP_FREE: begin
              res_ok_nxt = 1'b1;
              b_nxt      = ptr_b;
              state_nxt  = (in_data.payload_offset == 16'd0) ? ST_FIN : ST_FR_0;
            end
            OP_CHECK_BLK: begin
              b_nxt     = ptr_b;
              state_nxt = ST_CK_0;
            end
            OP_CHECK_HEAP: begin
              b_nxt     = '0;
              heap_nxt  = 1'b1;
              state_nxt = ST_CK_0;
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.ok            = res_ok_r;
          out_data_nxt.result_offset = res_off_r;
          state_nxt                  = ST_IDLE;
        end
      end

      // ---- init ----
      ST_IN_W0: begin
        mem_we    = 1'b1;
        mem_addr  = widx('0, HW_FLAG);
        mem_wd    = {VALID_MARK, 16'd0};
        state_nxt = ST_IN_W1;
      end
      ST_IN_W1: begin
        mem_we    = 1'b1;
        mem_addr  = widx('0, HW_SIZE);
        mem_wd    = init_e - HDR_BYTES;
        state_nxt = ST_IN_W2;
      end
      ST_IN_W2: begin
        mem_we    = 1'b1;
        mem_addr  = widx('0, HW_PREV);
        state_nxt = ST_IN_W3;
      end
      ST_IN_W3: begin
        mem_we     = 1'b1;
        mem_addr   = widx('0, HW_NEXT);
        res_ok_nxt = 1'b1;
        state_nxt  = ST_FIN;
      end

      // ---- alloc walk ----
      ST_AL_RD0: begin
        mem_addr  = widx(b_r, HW_FLAG);
        state_nxt = ST_AL_FLAG;
      end
      ST_AL_FLAG: begin
        w0_nxt = rd;
        if (rd[15:0] == 16'd0) begin
          mem_addr  = widx(b_r, HW_SIZE);
          state_nxt = ST_AL_SIZE;
        end else begin
          mem_addr  = widx(b_r, HW_NEXT);
          state_nxt = ST_AL_NEXT;
        end
      end
      ST_AL_SIZE: begin
        if (rd >= sz_r) begin
          if ((rd - sz_r) <= MAX_SLACK) begin
            mem_we      = 1'b1;
            mem_addr    = widx(b_r, HW_FLAG);
            mem_wd      = {w0_r[31:16], 16'd1};
            res_ok_nxt  = 1'b1;
            res_off_nxt = 16'(b_r + H'(HDR_BYTES));
            state_nxt   = ST_FIN;
          end else begin
            rest_nxt  = rd - HDR_BYTES - sz_r;
            sp_nxt    = norm(b_r + H'(HDR_BYTES) + sz_r[H-1:0]);
            mem_addr  = widx(b_r, HW_NEXT);
            state_nxt = ST_SP_NX;
          end
        end else begin
          mem_addr  = widx(b_r, HW_NEXT);
          state_nxt = ST_AL_NEXT;
        end
      end
      ST_AL_NEXT: begin
        if (rd_n == '0 || cnt_r == '1) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt   = cnt_r + CW'(1);
          b_nxt     = rd_n;
          mem_addr  = widx(rd_n, HW_FLAG);
          state_nxt = ST_AL_FLAG;
        end
      end

      // ---- alloc split ----
      ST_SP_NX: begin
        n_nxt     = rd_n;
        mem_we    = 1'b1;
        mem_addr  = widx(b_r, HW_FLAG);
        mem_wd    = {w0_r[31:16], 16'd1};
        state_nxt = ST_SP_W1;
      end
      ST_SP_W1: begin
        mem_we    = 1'b1;
        mem_addr  = widx(b_r, HW_SIZE);
        mem_wd    = sz_r;
        state_nxt = ST_SP_H0;
      end
      ST_SP_H0: begin
        mem_we    = 1'b1;
        mem_addr  = widx(sp_r, HW_FLAG);
        mem_wd    = {VALID_MARK, 16'd0};
        state_nxt = ST_SP_H1;
      end
      ST_SP_H1: begin
        mem_we    = 1'b1;
        mem_addr  = widx(sp_r, HW_SIZE);
        mem_wd    = rest_r;
        state_nxt = ST_SP_H2;
      end
      ST_SP_H2: begin
        mem_we    = 1'b1;
        mem_addr  = widx(sp_r, HW_PREV);
        mem_wd    = 32'(b_r);
        state_nxt = ST_SP_H3;
      end
      ST_SP_H3: begin
        mem_we    = 1'b1;
        mem_addr  = widx(sp_r, HW_NEXT);
        mem_wd    = 32'(n_r);
        state_nxt = ST_SP_LINK;
      end
      ST_SP_LINK: begin
        mem_we    = 1'b1;
        mem_addr  = widx(b_r, HW_NEXT);
        mem_wd    = 32'(sp_r);
        state_nxt = ST_SP_RD;
      end
      ST_SP_RD: begin
        mem_addr  = widx(sp_r, HW_NEXT);
        state_nxt = ST_SP_PREV;
      end
      ST_SP_PREV: begin
        if (rd_n != '0) begin
          mem_we   = 1'b1;
          mem_addr = widx(rd_n, HW_PREV);
          mem_wd   = 32'(sp_r);
        end
        res_ok_nxt  = 1'b1;
        res_off_nxt = 16'(b_r + H'(HDR_BYTES));
        state_nxt   = ST_FIN;
      end

      // ---- free: clear flag, merge with next ----
      ST_FR_0: begin
        mem_addr  = widx(b_r, HW_FLAG);
        state_nxt = ST_FR_1;
      end
      ST_FR_1: begin
        mem_we    = 1'b1;
        mem_addr  = widx(b_r, HW_FLAG);
        mem_wd    = {rd[31:16], 16'd0};
        state_nxt = ST_FR_2;
      end
      ST_FR_2: begin
        mem_addr  = widx(b_r, HW_NEXT);
        state_nxt = ST_FR_3;
      end
      ST_FR_3: begin
        n_nxt = rd_n;
        if (rd_n == '0) begin
          state_nxt = ST_FR_P0;
        end else begin
          mem_addr  = widx(rd_n, HW_FLAG);
          state_nxt = ST_FR_4;
        end
      end
      ST_FR_4: begin
        if (rd[15:0] != 16'd0) begin
          state_nxt = ST_FR_P0;
        end else begin
          mem_addr  = widx(b_r, HW_SIZE);
          state_nxt = ST_FR_5;
        end
      end
      ST_FR_5: begin
        t_nxt     = rd;
        mem_addr  = widx(n_r, HW_SIZE);
        state_nxt = ST_FR_6;
      end
      ST_FR_6: begin
        mem_we    = 1'b1;
        mem_addr  = widx(b_r, HW_SIZE);
        mem_wd    = t_r + HDR_BYTES + rd;
        state_nxt = ST_FR_7;
      end
      ST_FR_7: begin
        mem_addr  = widx(n_r, HW_FLAG);
        state_nxt = ST_FR_8;
      end
      ST_FR_8: begin
        mem_we    = 1'b1;
        mem_addr  = widx(n_r, HW_FLAG);
        mem_wd    = {16'd0, rd[15:0]};
        state_nxt = ST_FR_9;
      end
      ST_FR_9: begin
        mem_addr  = widx(n_r, HW_NEXT);
        state_nxt = ST_FR_10;
      end
      ST_FR_10: begin
        mem_we    = 1'b1;
        mem_addr  = widx(b_r, HW_NEXT);
        mem_wd    = 32'(rd_n);
        state_nxt = ST_FR_11;
      end
      ST_FR_11: begin
        mem_addr  = widx(b_r, HW_NEXT);
        state_nxt = ST_FR_12;
      end
      ST_FR_12: begin
        if (rd_n != '0) begin
          mem_we   = 1'b1;
          mem_addr = widx(rd_n, HW_PREV);
          mem_wd   = 32'(b_r);
        end
        state_nxt = ST_FR_P0;
      end

      // ---- free: merge into previous ----
      ST_FR_P0: begin
        if (b_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          mem_addr  = widx(b_r, HW_PREV);
          state_nxt = ST_FR_P1;
        end
      end
      ST_FR_P1: begin
        pv_nxt    = rd_n;
        mem_addr  = widx(rd_n, HW_FLAG);
        state_nxt = ST_FR_P2;
      end
      ST_FR_P2: begin
        if (rd[15:0] != 16'd0) begin
          state_nxt = ST_FIN;
        end else begin
          mem_addr  = widx(b_r, HW_NEXT);
          state_nxt = ST_FR_P3;
        end
      end
      ST_FR_P3: begin
        mem_we    = 1'b1;
        mem_addr  = widx(pv_r, HW_NEXT);
        mem_wd    = 32'(rd_n);
        state_nxt = ST_FR_P4;
      end
      ST_FR_P4: begin
        mem_addr  = widx(b_r, HW_NEXT);
        state_nxt = ST_FR_P5;
      end
      ST_FR_P5: begin
        if (rd_n == '0) begin
          state_nxt = ST_FR_P8;
        end else begin
          n_nxt     = rd_n;
          mem_addr  = widx(b_r, HW_PREV);
          state_nxt = ST_FR_P6;
        end
      end
      ST_FR_P6: begin
        mem_we    = 1'b1;
        mem_addr  = widx(n_r, HW_PREV);
        mem_wd    = 32'(rd_n);
        state_nxt = ST_FR_P8;
      end
      ST_FR_P8: begin
        mem_addr  = widx(b_r, HW_FLAG);
        state_nxt = ST_FR_P9;
      end
      ST_FR_P9: begin
        mem_we    = 1'b1;
        mem_addr  = widx(b_r, HW_FLAG);
        mem_wd    = {16'd0, rd[15:0]};
        state_nxt = ST_FR_P10;
      end
      ST_FR_P10: begin
        mem_addr  = widx(b_r, HW_PREV);
        state_nxt = ST_FR_P11;
      end
      ST_FR_P11: begin
        // prev link is re-read: the writes above may have moved it
        pv_nxt    = rd_n;
        mem_addr  = widx(rd_n, HW_SIZE);
        state_nxt = ST_FR_P12;
      end
      ST_FR_P12: begin
        t_nxt     = rd;
        mem_addr  = widx(b_r, HW_SIZE);
        state_nxt = ST_FR_P13;
      end
      ST_FR_P13: begin
        mem_we    = 1'b1;
        mem_addr  = widx(pv_r, HW_SIZE);
        mem_wd    = t_r + HDR_BYTES + rd;
        state_nxt = ST_FIN;
      end

      // ---- block check ----
      ST_CK_0: begin
        mem_addr  = widx(b_r, HW_FLAG);
        state_nxt = ST_CK_1;
      end
      ST_CK_1: begin
        if (rd[31:16] != VALID_MARK) begin
          chk_done = 1'b1;
        end else begin
          mem_addr  = widx(b_r, HW_NEXT);
          state_nxt = ST_CK_2;
        end
      end
      ST_CK_2: begin
        n_nxt     = rd_n;
        mem_addr  = widx(rd_n, HW_FLAG);
        state_nxt = ST_CK_3;
      end
      ST_CK_3: begin
        if (rd[31:16] != VALID_MARK) begin
          chk_done = 1'b1;
        end else if (n_r != '0) begin
          mem_addr  = widx(n_r, HW_PREV);
          state_nxt = ST_CK_4;
        end else begin
          state_nxt = ST_CK_5;
        end
      end
      ST_CK_4: begin
        if (rd_n != b_r) begin
          chk_done = 1'b1;
        end else begin
          state_nxt = ST_CK_5;
        end
      end
      ST_CK_5: begin
        mem_addr  = widx(b_r, HW_PREV);
        state_nxt = ST_CK_6;
      end
      ST_CK_6: begin
        pv_nxt    = rd_n;
        mem_addr  = widx(rd_n, HW_FLAG);
        state_nxt = ST_CK_7;
      end
      ST_CK_7: begin
        if (rd[31:16] != VALID_MARK) begin
          chk_done = 1'b1;
        end else if (pv_r != '0) begin
          mem_addr  = widx(pv_r, HW_NEXT);
          state_nxt = ST_CK_8;
        end else begin
          state_nxt = ST_CK_9;
        end
      end
      ST_CK_8: begin
        if (rd_n != b_r) begin
          chk_done = 1'b1;
        end else begin
          state_nxt = ST_CK_9;
        end
      end
      ST_CK_9: begin
        if (n_r != '0) begin
          mem_addr  = widx(b_r, HW_SIZE);
          state_nxt = ST_CK_10;
        end else begin
          chk_done = 1'b1;
          chk_ok   = 1'b1;
        end
      end
      ST_CK_10: begin
        chk_done = 1'b1;
        chk_ok   = (n_r == norm(b_r + H'(HDR_BYTES) + rd[H-1:0]));
      end
      default: state_nxt = ST_IDLE;
    endcase

    // end of one block check: finish, or step to the next block of the heap
    if (chk_done) begin
      state_nxt  = ST_FIN;
      res_ok_nxt = chk_ok;
      if (chk_ok && heap_r && n_r != '0) begin
        if (cnt_r == '1) begin
          res_ok_nxt = 1'b0;
        end else begin
          cnt_nxt   = cnt_r + CW'(1);
          b_nxt     = n_r;
          state_nxt = ST_CK_0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    b_r        <= b_nxt;
    n_r        <= n_nxt;
    pv_r       <= pv_nxt;
    sp_r       <= sp_nxt;
    sz_r       <= sz_nxt;
    w0_r       <= w0_nxt;
    t_r        <= t_nxt;
    rest_r     <= rest_nxt;
    cnt_r      <= cnt_nxt;
    heap_r     <= heap_nxt;
    res_ok_r   <= res_ok_nxt;
    res_off_r  <= res_off_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_size_r <= HEAP_SIZE_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_HEAP_SIZE) begin
      heap_size_r <= pwdata[16:0];
    end
  end

  assign prdata    = (paddr[2] == REG_HEAP_SIZE) ? {15'd0, heap_size_r} : 32'd0;
  assign pready    = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> in_stall)
    else $error("item taken during header clear");
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !mem_we)
    else $error("header write while idle");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.ok |-> out_data_r.result_offset == 16'd0)
    else $error("failed result carries an offset");
  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && !(out_valid_r && out_stall) |=> out_valid_r)
    else $error("result lost at output register");
`endif

endmodule
